FILE: rtl/mrn_pkg.sv
package mrn_pkg;

   localparam int GRID_SIZE   = 16;
   localparam int STACK_DEPTH = 256;
   localparam int CELLS       = GRID_SIZE * GRID_SIZE;

   localparam logic [8:0]  DIST_MAX     = 9'd511;
   localparam logic [9:0]  NO_PATH      = 10'd999;
   localparam logic [20:0] FLOOD_BUDGET = 21'd1048576;

   // headings / sides
   localparam logic [1:0] DIR_UP    = 2'd0;
   localparam logic [1:0] DIR_RIGHT = 2'd1;
   localparam logic [1:0] DIR_DOWN  = 2'd2;
   localparam logic [1:0] DIR_LEFT  = 2'd3;

   // modes
   localparam logic [2:0] MODE_SCAN  = 3'd0;
   localparam logic [2:0] MODE_LEFT  = 3'd1;
   localparam logic [2:0] MODE_RIGHT = 3'd2;
   localparam logic [2:0] MODE_FLOOD = 3'd3;
   localparam logic [2:0] MODE_LOAD  = 3'd4;

   localparam logic [3:0] LAST_IDX = 4'(GRID_SIZE - 1);

   // wall word: bit 0 left, 1 top, 2 right, 3 down
   function automatic logic [1:0] side_idx(input logic [1:0] d);
      return 2'(d + 2'd1);
   endfunction

   function automatic logic has_nb(input logic [3:0] r, input logic [3:0] c,
                                   input logic [1:0] d);
      logic res;
      case (d)
         DIR_UP:    res = (r != 4'd0);
         DIR_RIGHT: res = (c != LAST_IDX);
         DIR_DOWN:  res = (r != LAST_IDX);
         default:   res = (c != 4'd0);
      endcase
      return res;
   endfunction

   function automatic logic [7:0] nb_addr(input logic [3:0] r, input logic [3:0] c,
                                          input logic [1:0] d);
      logic [3:0] nr;
      logic [3:0] nc;
      nr = r;
      nc = c;
      case (d)
         DIR_UP:    nr = 4'(r - 4'd1);
         DIR_RIGHT: nc = 4'(c + 4'd1);
         DIR_DOWN:  nr = 4'(r + 4'd1);
         default:   nc = 4'(c - 4'd1);
      endcase
      return {nr, nc};
   endfunction

   function automatic logic is_open(input logic [3:0] r, input logic [3:0] c,
                                    input logic [3:0] walls, input logic [1:0] d);
      return has_nb(r, c, d) && !walls[side_idx(d)];
   endfunction

endpackage

FILE: rtl/maze_robot_navigator.sv
// Grid-maze navigator for a 16 x 16 maze. Each request item carries a mode
// (scan walls, left-wall move, right-wall move, flood and move, load distance)
// and gives exactly one response item with the position, heading and stored
// distance of the current cell after the step. Wall, distance and flood stack
// maps sit in simple dual-port synchronous RAMs with registered reads;
// each item reads, modifies and writes back in sequence, so no read meets a
// write to the same entry still in flight. After reset a clearing pass over all
// 256 cells zeroes the wall and distance maps while req_tready stays low.
// Load and unused-mode items go straight to the output; wall-follow items
// read the current cell's walls; scan items read and update the neighbours'
// wall words one side after another. A flood item pushes the current cell,
// then for each cell popped reads the neighbours' distances one side after
// another, and ends with a final step. A response item not yet taken holds
// the next item's response in the output state with req_tready low.
module maze_robot_navigator
   import mrn_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // mode[2:0], wall_left[3], wall_top[4], wall_right[5], wall_down[6],
   // cell_row[10:7], cell_col[14:11], dist_value[23:15]
   input  logic [23:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // row[3:0], col[7:4], heading[9:8], here_dist[18:10], stack_overflow[19],
   // zero fill[23:20]
   output logic [23:0] rsp_tdata
);

   localparam logic [4:0] S_CLEAR  = 5'd0;
   localparam logic [4:0] S_IDLE   = 5'd1;
   localparam logic [4:0] S_SC_W   = 5'd2;
   localparam logic [4:0] S_SC_N   = 5'd3;
   localparam logic [4:0] S_SC_NW  = 5'd4;
   localparam logic [4:0] S_FOL    = 5'd5;
   localparam logic [4:0] S_PUSH0  = 5'd6;
   localparam logic [4:0] S_POP    = 5'd7;
   localparam logic [4:0] S_PWAIT  = 5'd8;
   localparam logic [4:0] S_WA     = 5'd9;
   localparam logic [4:0] S_WQ     = 5'd10;
   localparam logic [4:0] S_NB     = 5'd11;
   localparam logic [4:0] S_NBQ    = 5'd12;
   localparam logic [4:0] S_EVAL   = 5'd13;
   localparam logic [4:0] S_PUSH   = 5'd14;
   localparam logic [4:0] S_FIN    = 5'd15;
   localparam logic [4:0] S_OUT    = 5'd16;

   // memories
   logic [3:0]  wall_mem  [CELLS];
   logic [8:0]  dist_mem  [CELLS];
   logic [16:0] stack_mem [STACK_DEPTH];

   logic [7:0]  wall_ra, wall_wa, dist_ra, dist_wa, stack_ra, stack_wa;
   logic [3:0]  wall_wd, wall_q;
   logic [8:0]  dist_wd, dist_q;
   logic [16:0] stack_wd, stack_q;
   logic        wall_we, dist_we, stack_we;

   logic [4:0]  state_ff, state_in;
   logic [7:0]  clr_ff, clr_in;
   logic [3:0]  row_ff, row_in, col_ff, col_in;
   logic [1:0]  head_ff, head_in;
   logic [2:0]  mode_ff, mode_in;
   logic [3:0]  sns_ff, sns_in;
   logic [3:0]  wr_ff, wr_in, wc_ff, wc_in;
   logic [8:0]  wdist_ff, wdist_in;
   logic [3:0]  walls_ff, walls_in;
   logic [1:0]  dir_ff, dir_in;
   logic [9:0]  val_ff [4];
   logic [9:0]  val_in [4];
   logic        final_ff, final_in;
   logic [8:0]  sp_ff, sp_in;
   logic [20:0] pops_ff, pops_in;
   logic        ovf_ff, ovf_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [19:0] rsp_data_ff, rsp_data_in;

   logic        req_acc;
   logic [1:0]  behind;
   logic [9:0]  min_val;
   logic [1:0]  min_dir;
   logic [8:0]  new_dist;
   logic [7:0]  sp_dec;
   logic [1:0]  fol_dir;
   logic [1:0]  ord [3];
   logic        fol_hit;

   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_data_ff};
   assign behind     = 2'(head_ff + 2'd2);
   assign sp_dec     = 8'(sp_ff - 9'd1);

   // pick the lowest neighbour; later sides win ties (left, down, right, top)
   always_comb begin
      min_val = NO_PATH;
      min_dir = DIR_UP;
      for (int i = 0; i < 4; i++) begin
         if (val_ff[i] <= min_val) begin
            min_val = val_ff[i];
            min_dir = 2'(i);
         end
      end
      new_dist = (min_val >= {1'b0, DIST_MAX}) ? DIST_MAX : 9'(min_val + 10'd1);
   end

   // wall-follow order: side rule first, then ahead, then the other side
   always_comb begin
      ord[0] = (mode_ff == MODE_LEFT) ? 2'(head_ff + 2'd3) : 2'(head_ff + 2'd1);
      ord[1] = head_ff;
      ord[2] = (mode_ff == MODE_LEFT) ? 2'(head_ff + 2'd1) : 2'(head_ff + 2'd3);
      fol_hit = 1'b0;
      fol_dir = behind;
      for (int k = 2; k >= 0; k--) begin
         if (is_open(row_ff, col_ff, wall_q, ord[k])) begin
            fol_hit = 1'b1;
            fol_dir = ord[k];
         end
      end
   end

   // read addresses
   always_comb begin
      wall_ra  = {row_ff, col_ff};
      dist_ra  = {row_ff, col_ff};
      stack_ra = sp_dec;
      case (state_ff)
         S_SC_N: wall_ra = nb_addr(row_ff, col_ff, dir_ff);
         S_WA:   wall_ra = {wr_ff, wc_ff};
         S_NB:   dist_ra = nb_addr(wr_ff, wc_ff, dir_ff);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      wall_q  <= wall_mem[wall_ra];
      dist_q  <= dist_mem[dist_ra];
      stack_q <= stack_mem[stack_ra];
      if (wall_we) begin
         wall_mem[wall_wa] <= wall_wd;
      end
      if (dist_we) begin
         dist_mem[dist_wa] <= dist_wd;
      end
      if (stack_we) begin
         stack_mem[stack_wa] <= stack_wd;
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      head_in      = head_ff;
      mode_in      = mode_ff;
      sns_in       = sns_ff;
      wr_in        = wr_ff;
      wc_in        = wc_ff;
      wdist_in     = wdist_ff;
      walls_in     = walls_ff;
      dir_in       = dir_ff;
      val_in       = val_ff;
      final_in     = final_ff;
      sp_in        = sp_ff;
      pops_in      = pops_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      wall_we      = 1'b0;
      wall_wa      = {row_ff, col_ff};
      wall_wd      = wall_q;
      dist_we      = 1'b0;
      dist_wa      = {wr_ff, wc_ff};
      dist_wd      = new_dist;
      stack_we     = 1'b0;
      stack_wa     = sp_ff[7:0];
      stack_wd     = {row_ff, col_ff, dist_q};

      case (state_ff)
         S_CLEAR: begin
            // clear both maps one cell a cycle
            wall_we  = 1'b1;
            wall_wa  = clr_ff;
            wall_wd  = 4'd0;
            dist_we  = 1'b1;
            dist_wa  = clr_ff;
            dist_wd  = 9'd0;
            clr_in   = 8'(clr_ff + 8'd1);
            if (clr_ff == 8'(CELLS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_acc) begin
               mode_in = req_tdata[2:0];
               // sensed sides indexed by direction: top, right, down, left
               sns_in  = {req_tdata[3], req_tdata[6], req_tdata[5], req_tdata[4]};
               ovf_in  = 1'b0;
               case (req_tdata[2:0])
                  MODE_SCAN:  state_in = S_SC_W;
                  MODE_LEFT,
                  MODE_RIGHT: state_in = S_FOL;
                  MODE_FLOOD: begin
                     sp_in    = 9'd0;
                     pops_in  = 21'd0;
                     state_in = S_PUSH0;
                  end
                  MODE_LOAD: begin
                     dist_we  = 1'b1;
                     dist_wa  = {req_tdata[10:7], req_tdata[14:11]};
                     dist_wd  = req_tdata[23:15];
                     state_in = S_FIN;
                  end
                  default: state_in = S_FIN;
               endcase
            end
         end
         S_SC_W: begin
            // write all sensed sides but the one behind into the current cell
            wall_we = 1'b1;
            for (int d = 0; d < 4; d++) begin
               if (2'(d) != behind) begin
                  wall_wd[side_idx(2'(d))] = sns_ff[d];
               end
            end
            dir_in   = DIR_UP;
            state_in = S_SC_N;
         end
         S_SC_N: begin
            if (dir_ff != behind && has_nb(row_ff, col_ff, dir_ff)) begin
               state_in = S_SC_NW;
            end else if (dir_ff == DIR_LEFT) begin
               state_in = S_FIN;
            end else begin
               dir_in = 2'(dir_ff + 2'd1);
            end
         end
         S_SC_NW: begin
            // mirror the side onto the neighbour
            wall_we = 1'b1;
            wall_wa = nb_addr(row_ff, col_ff, dir_ff);
            wall_wd[side_idx(2'(dir_ff + 2'd2))] = sns_ff[dir_ff];
            if (dir_ff == DIR_LEFT) begin
               state_in = S_FIN;
            end else begin
               dir_in   = 2'(dir_ff + 2'd1);
               state_in = S_SC_N;
            end
         end
         S_FOL: begin
            // a dead end turns back whatever the map says
            head_in = fol_hit ? fol_dir : behind;
            if (has_nb(row_ff, col_ff, head_in)) begin
               {row_in, col_in} = nb_addr(row_ff, col_ff, head_in);
            end
            state_in = S_FIN;
         end
         S_PUSH0: begin
            stack_we = 1'b1;
            stack_wa = 8'd0;
            sp_in    = 9'd1;
            state_in = S_POP;
         end
         S_POP: begin
            if (sp_ff == 9'd0 || pops_ff >= FLOOD_BUDGET) begin
               if (sp_ff != 9'd0) begin
                  ovf_in = 1'b1;
                  sp_in  = 9'd0;
               end
               wr_in    = row_ff;
               wc_in    = col_ff;
               final_in = 1'b1;
               state_in = S_WA;
            end else begin
               pops_in  = 21'(pops_ff + 21'd1);
               sp_in    = 9'(sp_ff - 9'd1);
               state_in = S_PWAIT;
            end
         end
         S_PWAIT: begin
            {wr_in, wc_in, wdist_in} = stack_q;
            final_in = 1'b0;
            state_in = S_WA;
         end
         S_WA: state_in = S_WQ;
         S_WQ: begin
            walls_in = wall_q;
            dir_in   = DIR_UP;
            state_in = S_NB;
         end
         S_NB: begin
            if (is_open(wr_ff, wc_ff, walls_ff, dir_ff)) begin
               state_in = S_NBQ;
            end else begin
               val_in[dir_ff] = NO_PATH;
               if (dir_ff == DIR_LEFT) begin
                  state_in = S_EVAL;
               end else begin
                  dir_in = 2'(dir_ff + 2'd1);
               end
            end
         end
         S_NBQ: begin
            val_in[dir_ff] = {1'b0, dist_q};
            if (dir_ff == DIR_LEFT) begin
               state_in = S_EVAL;
            end else begin
               dir_in   = 2'(dir_ff + 2'd1);
               state_in = S_NB;
            end
         end
         S_EVAL: begin
            if (final_ff) begin
               head_in = min_dir;
               if (has_nb(row_ff, col_ff, min_dir)) begin
                  {row_in, col_in} = nb_addr(row_ff, col_ff, min_dir);
               end
               state_in = S_FIN;
            end else if (new_dist != wdist_ff) begin
               dist_we  = 1'b1;
               dir_in   = DIR_UP;
               state_in = S_PUSH;
            end else begin
               state_in = S_POP;
            end
         end
         S_PUSH: begin
            // push open neighbours top, right, down, left; drop on a full stack
            if (is_open(wr_ff, wc_ff, walls_ff, dir_ff)) begin
               if (sp_ff >= 9'(STACK_DEPTH)) begin
                  ovf_in = 1'b1;
               end else begin
                  stack_we = 1'b1;
                  stack_wd = {nb_addr(wr_ff, wc_ff, dir_ff), val_ff[dir_ff][8:0]};
                  sp_in    = 9'(sp_ff + 9'd1);
               end
            end
            if (dir_ff == DIR_LEFT) begin
               state_in = S_POP;
            end else begin
               dir_in = 2'(dir_ff + 2'd1);
            end
         end
         S_FIN: state_in = S_OUT;
         S_OUT: begin
            // hold until the response register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {ovf_ff, dist_q, head_ff, col_ff, row_ff};
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= 8'd0;
         row_ff       <= LAST_IDX;
         col_ff       <= 4'd0;
         head_ff      <= DIR_UP;
         sp_ff        <= 9'd0;
         pops_ff      <= 21'd0;
         ovf_ff       <= 1'b0;
         final_ff     <= 1'b0;
         dir_ff       <= DIR_UP;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         head_ff      <= head_in;
         sp_ff        <= sp_in;
         pops_ff      <= pops_in;
         ovf_ff       <= ovf_in;
         final_ff     <= final_in;
         dir_ff       <= dir_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      sns_ff      <= sns_in;
      wr_ff       <= wr_in;
      wc_ff       <= wc_in;
      wdist_ff    <= wdist_in;
      walls_ff    <= walls_in;
      val_ff      <= val_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import mrn_pkg::*;

   localparam int N_DIRECTED   = 20;
   localparam int N_RANDOM     = 300;
   localparam int FLOOD_CAP    = 4000;   // pops allowed for one random flood item
   localparam int HOLD_CYCLES  = 3000;
   localparam int MAX_REPORTS  = 10;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   // mode[2:0], wall_left[3], wall_top[4], wall_right[5], wall_down[6],
   // cell_row[10:7], cell_col[14:11], dist_value[23:15]
   logic [23:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   // row[3:0], col[7:4], heading[9:8], here_dist[18:10], stack_overflow[19],
   // zero fill[23:20]
   logic [23:0] rsp_tdata;

   maze_robot_navigator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Mirror of the navigator: wall map, distance map, pose and flood stack
   logic [3:0]  wall_map [CELLS];
   logic [8:0]  dist_map [CELLS];
   logic [8:0]  dist_save [CELLS];
   logic [3:0]  pos_row;
   logic [3:0]  pos_col;
   logic [1:0]  pos_head;
   logic [7:0]  stk_cell [STACK_DEPTH];
   logic [8:0]  stk_dist [STACK_DEPTH];
   int          stk_count;
   logic        ovf_flag;

   logic [19:0] pending_rsp[$];
   int          mismatches;
   int          unexpected;
   longint      cycle_count;
   longint      work_estimate;
   bit          calm;
   bit          hold_request;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Wall word: bit 0 left, 1 top, 2 right, 3 down; side d maps to bit d+1
   function automatic logic [1:0] wall_bit(input logic [1:0] d);
      return 2'(d + 2'd1);
   endfunction

   function automatic logic on_grid(input logic [3:0] r, input logic [3:0] c,
                                    input logic [1:0] d);
      case (d)
         DIR_UP:    return r != 4'd0;
         DIR_RIGHT: return c != LAST_IDX;
         DIR_DOWN:  return r != LAST_IDX;
         default:   return c != 4'd0;
      endcase
   endfunction

   function automatic logic [7:0] step_cell(input logic [3:0] r, input logic [3:0] c,
                                            input logic [1:0] d);
      case (d)
         DIR_UP:    return {4'(r - 4'd1), c};
         DIR_RIGHT: return {r, 4'(c + 4'd1)};
         DIR_DOWN:  return {4'(r + 4'd1), c};
         default:   return {r, 4'(c - 4'd1)};
      endcase
   endfunction

   function automatic logic side_open(input logic [3:0] r, input logic [3:0] c,
                                      input logic [1:0] d);
      logic [3:0] w;
      w = wall_map[{r, c}];
      return on_grid(r, c, d) && !w[wall_bit(d)];
   endfunction

   // Lowest open neighbour; the later side wins a tie (left, down, right, top)
   task automatic lowest_neighbour(input logic [3:0] r, input logic [3:0] c,
                                   output logic [9:0] m, output logic [1:0] dir);
      logic [9:0] val [4];
      m = NO_PATH;
      for (int d = 0; d < 4; d++) begin
         val[d] = NO_PATH;
         if (side_open(r, c, 2'(d))) val[d] = {1'b0, dist_map[step_cell(r, c, 2'(d))]};
         if (val[d] < m) m = val[d];
      end
      dir = DIR_UP;
      for (int d = 0; d < 4; d++) if (val[d] == m) dir = 2'(d);
   endtask

   task automatic stack_push(input logic [7:0] cell_idx);
      if (stk_count >= STACK_DEPTH) begin
         ovf_flag = 1'b1;
      end else begin
         stk_cell[stk_count] = cell_idx;
         stk_dist[stk_count] = dist_map[cell_idx];
         stk_count++;
      end
   endtask

   task automatic advance_to(input logic [1:0] d);
      logic [7:0] nc;
      pos_head = d;
      if (on_grid(pos_row, pos_col, d)) begin
         nc = step_cell(pos_row, pos_col, d);
         pos_row = nc[7:4];
         pos_col = nc[3:0];
      end
   endtask

   task automatic wall_follow(input logic [1:0] o0, input logic [1:0] o1,
                              input logic [1:0] o2);
      if (side_open(pos_row, pos_col, o0)) advance_to(o0);
      else if (side_open(pos_row, pos_col, o1)) advance_to(o1);
      else if (side_open(pos_row, pos_col, o2)) advance_to(o2);
      else advance_to(2'(pos_head + 2'd2));
   endtask

   task automatic flood_relax(output int pops);
      logic [7:0] cell_idx;
      logic [8:0] carried;
      logic [9:0] m;
      logic [8:0] nv;
      logic [1:0] dir;
      pops = 0;
      stk_count = 0;
      stack_push({pos_row, pos_col});
      while (stk_count > 0) begin
         if (pops >= FLOOD_BUDGET) begin
            ovf_flag = 1'b1;
            stk_count = 0;
            break;
         end
         pops++;
         stk_count--;
         cell_idx = stk_cell[stk_count];
         carried = stk_dist[stk_count];
         lowest_neighbour(cell_idx[7:4], cell_idx[3:0], m, dir);
         nv = (m + 10'd1 > {1'b0, DIST_MAX}) ? DIST_MAX : 9'(m + 10'd1);
         if (carried != nv) begin
            dist_map[cell_idx] = nv;
            for (int d = 0; d < 4; d++)
               if (side_open(cell_idx[7:4], cell_idx[3:0], 2'(d)))
                  stack_push(step_cell(cell_idx[7:4], cell_idx[3:0], 2'(d)));
         end
      end
      lowest_neighbour(pos_row, pos_col, m, dir);
      advance_to(dir);
   endtask

   // Apply one request item to the mirror and return the response it implies
   task automatic predict_item(input logic [23:0] item, output logic [19:0] rsp,
                               output int pops);
      logic [2:0] mode;
      logic [3:0] sensed;   // indexed by side: up, right, down, left
      logic [7:0] cur;
      logic [7:0] nb;
      logic [1:0] b;
      mode = item[2:0];
      sensed = {item[3], item[6], item[5], item[4]};
      ovf_flag = 1'b0;
      pops = 0;
      case (mode)
         MODE_SCAN: begin
            cur = {pos_row, pos_col};
            for (int d = 0; d < 4; d++) begin
               if (2'(d) != 2'(pos_head + 2'd2)) begin
                  b = wall_bit(2'(d));
                  wall_map[cur][b] = sensed[d];
                  if (on_grid(pos_row, pos_col, 2'(d))) begin
                     nb = step_cell(pos_row, pos_col, 2'(d));
                     wall_map[nb][wall_bit(2'(d + 2))] = sensed[d];
                  end
               end
            end
         end
         MODE_LEFT:  wall_follow(2'(pos_head + 2'd3), pos_head, 2'(pos_head + 2'd1));
         MODE_RIGHT: wall_follow(2'(pos_head + 2'd1), pos_head, 2'(pos_head + 2'd3));
         MODE_FLOOD: flood_relax(pops);
         MODE_LOAD:  dist_map[{item[10:7], item[14:11]}] = item[23:15];
         default: ;
      endcase
      rsp = {ovf_flag, dist_map[{pos_row, pos_col}], pos_head, pos_col, pos_row};
   endtask

   function automatic logic [23:0] pack_req(input logic [2:0] mode, input logic [3:0] walls,
                                            input logic [3:0] r, input logic [3:0] c,
                                            input logic [8:0] v);
      // walls given as {down, right, top, left}
      return {v, c, r, walls, mode};
   endfunction

   function automatic logic [20:0] typed_rsp(input logic [3:0] r, input logic [3:0] c,
                                             input logic [1:0] h, input logic [8:0] here_dist,
                                             input logic ovf);
      return {1'b1, ovf, here_dist, h, c, r};
   endfunction

   function automatic logic [23:0] random_req();
      int pick;
      logic [8:0] v;
      pick = $urandom_range(0, 99);
      v = ($urandom_range(0, 9) < 7) ? 9'($urandom_range(480, 511)) : 9'($urandom);
      if (pick < 30) return pack_req(MODE_SCAN, 4'($urandom), 4'($urandom), 4'($urandom),
                                     9'($urandom));
      if (pick < 45) return pack_req(MODE_LEFT, 4'($urandom), 4'($urandom), 4'($urandom),
                                     9'($urandom));
      if (pick < 60) return pack_req(MODE_RIGHT, 4'($urandom), 4'($urandom), 4'($urandom),
                                     9'($urandom));
      if (pick < 80) return pack_req(MODE_FLOOD, 4'($urandom), 4'($urandom), 4'($urandom),
                                     9'($urandom));
      if (pick < 95) return pack_req(MODE_LOAD, 4'($urandom), 4'($urandom), 4'($urandom), v);
      return pack_req(3'($urandom_range(5, 7)), 4'($urandom), 4'($urandom), 4'($urandom),
                      9'($urandom));
   endfunction

   // Offer one item, idling first now and then; keep tvalid high back to back
   task automatic offer_item(input logic [23:0] item);
      if (!calm && $urandom_range(0, 99) < 6) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= item;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Stimulus: directed table, distance fill, then random traffic
   initial begin : stimulus
      logic [23:0] dir_req [N_DIRECTED];
      logic [20:0] dir_rsp [N_DIRECTED];
      logic [23:0] item;
      logic [19:0] rsp;
      logic [3:0]  sv_row;
      logic [3:0]  sv_col;
      logic [1:0]  sv_head;
      int          pops;

      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      calm = 1'b0;
      hold_request = 1'b0;
      mismatches = 0;
      unexpected = 0;
      work_estimate = 300;
      for (int i = 0; i < CELLS; i++) begin
         wall_map[i] = '0;
         dist_map[i] = '0;
      end
      pos_row = LAST_IDX;
      pos_col = 4'd0;
      pos_head = DIR_UP;
      stk_count = 0;

      // Unused modes, loads at the extremes, a closed cell flooded, turn-backs
      dir_req[0]  = pack_req(3'd5, 4'b0000, 4'd0, 4'd0, 9'd0);
      dir_rsp[0]  = typed_rsp(4'd15, 4'd0, DIR_UP, 9'd0, 1'b0);
      dir_req[1]  = 24'hFFFFFF;
      dir_rsp[1]  = typed_rsp(4'd15, 4'd0, DIR_UP, 9'd0, 1'b0);
      dir_req[2]  = pack_req(MODE_LOAD, 4'b1111, 4'd15, 4'd0, 9'd511);
      dir_rsp[2]  = typed_rsp(4'd15, 4'd0, DIR_UP, 9'd511, 1'b0);
      dir_req[3]  = pack_req(MODE_LOAD, 4'b0000, 4'd15, 4'd0, 9'd0);
      dir_rsp[3]  = typed_rsp(4'd15, 4'd0, DIR_UP, 9'd0, 1'b0);
      dir_req[4]  = pack_req(MODE_LOAD, 4'b0000, 4'd0, 4'd15, 9'd511);
      dir_rsp[4]  = typed_rsp(4'd15, 4'd0, DIR_UP, 9'd0, 1'b0);
      dir_req[5]  = pack_req(MODE_SCAN, 4'b1111, 4'd0, 4'd0, 9'd0);
      dir_rsp[5]  = typed_rsp(4'd15, 4'd0, DIR_UP, 9'd0, 1'b0);
      dir_req[6]  = pack_req(MODE_FLOOD, 4'b0000, 4'd0, 4'd0, 9'd0);
      dir_rsp[6]  = typed_rsp(4'd15, 4'd0, DIR_LEFT, 9'd511, 1'b0);
      dir_req[7]  = pack_req(MODE_LEFT, 4'b0000, 4'd0, 4'd0, 9'd0);
      dir_req[8]  = pack_req(MODE_SCAN, 4'b0000, 4'd0, 4'd0, 9'd0);
      dir_req[9]  = pack_req(MODE_RIGHT, 4'b0000, 4'd0, 4'd0, 9'd0);
      dir_req[10] = pack_req(MODE_LEFT, 4'b0000, 4'd0, 4'd0, 9'd0);
      dir_req[11] = pack_req(MODE_SCAN, 4'b1010, 4'd0, 4'd0, 9'd0);
      dir_req[12] = pack_req(MODE_RIGHT, 4'b0000, 4'd0, 4'd0, 9'd0);
      dir_req[13] = pack_req(MODE_SCAN, 4'b0101, 4'd0, 4'd0, 9'd0);
      dir_req[14] = pack_req(MODE_LEFT, 4'b0000, 4'd0, 4'd0, 9'd0);
      dir_req[15] = pack_req(3'd6, 4'b1111, 4'd15, 4'd15, 9'd511);
      dir_req[16] = pack_req(MODE_LOAD, 4'b0000, 4'd7, 4'd8, 9'h155);
      dir_req[17] = pack_req(MODE_LOAD, 4'b0000, 4'd8, 4'd7, 9'h0AA);
      dir_req[18] = pack_req(MODE_LEFT, 4'b1111, 4'd0, 4'd0, 9'd0);
      dir_req[19] = pack_req(MODE_RIGHT, 4'b0000, 4'd0, 4'd0, 9'd0);
      for (int i = 7; i < N_DIRECTED; i++) dir_rsp[i] = '0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < N_DIRECTED; i++) begin
         predict_item(dir_req[i], rsp, pops);
         pending_rsp.push_back(dir_rsp[i][20] ? dir_rsp[i][19:0] : rsp);
         work_estimate += 16 * pops + 40;
         offer_item(dir_req[i]);
      end

      // Saturate the distance map so later floods settle in few pops; no idling here
      calm = 1'b1;
      for (int i = 0; i < CELLS; i++) begin
         item = pack_req(MODE_LOAD, 4'($urandom), 4'(i / GRID_SIZE), 4'(i % GRID_SIZE),
                         DIST_MAX);
         predict_item(item, rsp, pops);
         pending_rsp.push_back(rsp);
         work_estimate += 40;
         offer_item(item);
      end
      calm = 1'b0;

      for (int i = 0; i < N_RANDOM; i++) begin
         if (i == 150) hold_request = 1'b1;
         item = random_req();
         if (item[2:0] == MODE_FLOOD) begin
            dist_save = dist_map;
            sv_row = pos_row;
            sv_col = pos_col;
            sv_head = pos_head;
         end
         predict_item(item, rsp, pops);
         // Swap a runaway flood for a scan and roll the mirror back
         if (pops > FLOOD_CAP) begin
            dist_map = dist_save;
            pos_row = sv_row;
            pos_col = sv_col;
            pos_head = sv_head;
            item[2:0] = MODE_SCAN;
            predict_item(item, rsp, pops);
         end
         pending_rsp.push_back(rsp);
         work_estimate += 16 * pops + 40;
         offer_item(item);
      end
      req_tvalid <= 1'b0;

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (64) @(posedge clock);
      if (mismatches == 0 && unexpected == 0 && pending_rsp.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Receiver: random back-pressure, plus one long hold so the block backs up
   initial begin : receiver
      int hold_left;
      bit hold_taken;
      hold_left = 0;
      hold_taken = 1'b0;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 6);
         end
      end
   end

   // Check each response item against the oldest prediction
   always @(posedge clock) begin
      logic [19:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rsp.size() == 0) begin
            unexpected++;
            if (mismatches + unexpected <= MAX_REPORTS)
               $display("unexpected response item %h", rsp_tdata);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_tdata[19:0] !== want) begin
               mismatches++;
               if (mismatches + unexpected <= MAX_REPORTS)
                  $display("mismatch: row %0d/%0d col %0d/%0d head %0d/%0d dist %0d/%0d ovf %0d/%0d",
                           want[3:0], rsp_tdata[3:0], want[7:4], rsp_tdata[7:4],
                           want[9:8], rsp_tdata[9:8], want[18:10], rsp_tdata[18:10],
                           want[19], rsp_tdata[19]);
            end
         end
      end
   end

   // Watchdog: limit scales with the predicted work, several times over
   initial begin : watchdog
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > 4 * work_estimate + 4 * HOLD_CYCLES + 50000) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

endmodule

FILE: sim.f
rtl/mrn_pkg.sv
rtl/maze_robot_navigator.sv
sim/testbench.sv
